/* rtl/core/i2da_pkg.sv */
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants for the integer to decimal ascii converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

	localparam int VALUE_W    = 32;
	localparam int VALUE_BITS = 32;
	localparam int NDIG       = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int SHIFT_W    = $clog2(VALUE_BITS + 1);
	localparam int IDX_W      = $clog2(NDIG);
	localparam int ND_W       = $clog2(NDIG + 1);
	localparam int TOT_W      = $clog2(NDIG + 2);
	localparam int COUNT_W    = 4;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               is_signed;
	} num_item_t;

	typedef struct packed {
		logic [7:0]         ascii_char;
		logic               last;
		logic [COUNT_W-1:0] char_count;
	} text_item_t;

	typedef logic [NDIG-1:0][3:0] bcd_t;

	typedef struct packed {
		logic                  start;
		logic [VALUE_BITS-1:0] mag;
	} dab_cmd_t;

	typedef struct packed {
		logic start;
		logic neg;
	} emit_cmd_t;

endpackage

/* rtl/core/i2da_dabble.sv */
// ----------------------------------------------------------------------------
// i2da_dabble
// Shift and add-3 unit: converts the magnitude to packed bcd, one bit a cycle.
// ----------------------------------------------------------------------------
module i2da_dabble (
	input  logic              clk,
	input  logic              arst_n,
	input  i2da_pkg::dab_cmd_t cmd,
	output logic              busy,
	output i2da_pkg::bcd_t    bcd
);
	import i2da_pkg::*;

	localparam int SW = NDIG * 4 + VALUE_BITS;

	logic [SHIFT_W-1:0]    cnt_q;
	logic [VALUE_BITS-1:0] bin_q;
	bcd_t                  bcd_q;
	bcd_t                  adj;
	logic [SW-1:0]         joined;
	logic [SW-1:0]         shifted;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
		end
		joined  = {adj, bin_q};
		shifted = {joined[SW-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start) begin
			cnt_q <= SHIFT_W'(VALUE_BITS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			bin_q <= cmd.mag;
			bcd_q <= '0;
		end else if (busy) begin
			bin_q <= shifted[VALUE_BITS-1:0];
			bcd_q <= shifted[SW-1:VALUE_BITS];
		end
	end

	assign busy = (cnt_q != '0);
	assign bcd  = bcd_q;

endmodule

/* rtl/core/i2da_emit.sv */
// ----------------------------------------------------------------------------
// i2da_emit
// Walks the bcd digits from the most significant nonzero one down and sends
// one character a cycle, unless text_ready holds it, through an output register.
// ----------------------------------------------------------------------------
module i2da_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i2da_pkg::emit_cmd_t   cmd,
	input  i2da_pkg::bcd_t        bcd,
	output logic                  busy,
	output logic                  text_valid,
	input  logic                  text_ready,
	output i2da_pkg::text_item_t  text
);
	import i2da_pkg::*;

	logic              active_q;
	logic              minus_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TOT_W-1:0]  total_q;
	logic              out_valid_q;
	text_item_t        out_q;
	logic [ND_W-1:0]   nd;
	logic              fire;
	logic              is_last;
	text_item_t        next_item;

	always_comb begin
		nd = ND_W'(1);
		for (int i = 0; i < NDIG; i++) begin
			if (bcd[i] != 4'd0) begin
				nd = ND_W'(i + 1);
			end
		end
	end

	assign fire    = active_q && (!out_valid_q || text_ready);
	assign is_last = !minus_q && (idx_q == '0);

	always_comb begin
		next_item.ascii_char = minus_q ? CHAR_MINUS : (CHAR_ZERO + {4'd0, bcd[idx_q]});
		next_item.last       = is_last;
		next_item.char_count = is_last ? COUNT_W'(total_q) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			minus_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				active_q <= 1'b1;
				minus_q  <= cmd.neg;
			end else if (fire) begin
				if (minus_q) begin
					minus_q <= 1'b0;
				end else if (idx_q == '0) begin
					active_q <= 1'b0;
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (text_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			idx_q   <= IDX_W'(nd - 1'b1);
			total_q <= TOT_W'(nd) + TOT_W'(cmd.neg);
		end else if (fire && !minus_q && (idx_q != '0)) begin
			idx_q <= idx_q - 1'b1;
		end
		if (fire) begin
			out_q <= next_item;
		end
	end

	assign busy       = active_q;
	assign text_valid = out_valid_q;
	assign text       = out_q;

endmodule

/* rtl/core/integer_to_decimal_ascii_top.sv */
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_top
// Converts a 32-bit value, signed or unsigned, to its decimal ascii text.
// ----------------------------------------------------------------------------
// usage:
//   num channel (num_valid/num_ready/num) takes one item: value and is_signed.
//   text channel (text_valid/text_ready/text) returns one character per item,
//   most significant first, a leading '-' for negative signed values, no
//   leading zeros; the final character has last set and the character count.
//   num_ready is high only while the converter is idle.
// flow and throughput:
//   the shift and add-3 unit converts the magnitude bit by bit after accept;
//   then the digit walk picks the leading digit and loads each character into
//   the output register, one character per cycle while text_ready is high.
//   a new item is taken only once the walk has issued its last character.
// reset:
//   arst_n clears the sequencer and the output valid; nothing else to set up.
// stalls:
//   when text_ready is low the character is held in the output register and
//   the digit walk waits; no character is lost or repeated.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  num_valid,
	output logic                  num_ready,
	input  i2da_pkg::num_item_t   num,
	output logic                  text_valid,
	input  logic                  text_ready,
	output i2da_pkg::text_item_t  text
);
	import i2da_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic                  neg_q;
	logic [VALUE_BITS-1:0] v;
	logic                  neg;
	logic                  accept;
	dab_cmd_t              dab_cmd;
	emit_cmd_t             emit_cmd;
	logic                  dab_busy;
	logic                  emit_busy;
	bcd_t                  bcd;

	assign num_ready = (state_q == ST_IDLE);
	assign accept    = num_valid && num_ready;
	assign v         = VALUE_BITS'(num.value);
	assign neg       = num.is_signed && v[VALUE_BITS-1];

	assign dab_cmd.start  = accept;
	assign dab_cmd.mag    = neg ? (~v + 1'b1) : v;
	assign emit_cmd.start = (state_q == ST_CONV) && !dab_busy;
	assign emit_cmd.neg   = neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_CONV;
				ST_CONV: if (!dab_busy) state_q <= ST_EMIT;
				ST_EMIT: if (!emit_busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= neg;
		end
	end

	i2da_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dab_cmd),
		.busy   (dab_busy),
		.bcd    (bcd)
	);

	i2da_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (emit_cmd),
		.bcd        (bcd),
		.busy       (emit_busy),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text       (text)
	);

	a_conv_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> dab_busy)
		else $error("conversion did not start after accept");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!dab_busy && !emit_busy))
		else $error("units busy while idle");

	a_emit_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		emit_busy |-> (state_q == ST_EMIT))
		else $error("digit walk outside emit state");

	a_last_count: assert property (@(posedge clk) disable iff (!arst_n)
		(text_valid && !text.last) |-> (text.char_count == '0))
		else $error("count on a character that is not last");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer to decimal ascii converter. Numbers go
// in on the num channel. Each number accepted is turned into its expected
// text, one character per entry. Every character that leaves on the text
// channel is checked field by field against the oldest entry still pending.
// A directed set covers zero, the digit boundaries, the unsigned maximum and
// the most negative value. Random numbers then run under several idle and
// stall mixes. Last comes a long receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
import i2da_pkg::*;

class decimal_text_scoreboard;
	text_item_t  expected_chars[$];
	int          errors;
	int          numbers_seen;
	int          negatives_seen;
	int          chars_checked;
	bit [11:0]   lengths_seen;

	function new();
		errors = 0;
		numbers_seen = 0;
		negatives_seen = 0;
		chars_checked = 0;
		lengths_seen = '0;
	endfunction

	task report_mismatch(string msg);
		errors++;
		$display("tb_top: mismatch: %s", msg);
	endtask

	function int pending();
		return expected_chars.size();
	endfunction

	// turns one accepted number into its expected characters
	function void note_number(num_item_t it);
		logic [31:0]     v;
		logic            neg;
		longint unsigned mag;
		byte unsigned    digs[$];
		int              total;
		text_item_t      c;
		v = it.value;
		neg = it.is_signed & v[31];
		mag = neg ? ((64'd1 << 32) - v) : v;
		do begin
			digs.push_front(byte'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		total = digs.size() + (neg ? 1 : 0);
		if (neg) begin
			c.ascii_char = CHAR_MINUS;
			c.last = 1'b0;
			c.char_count = '0;
			expected_chars.push_back(c);
			negatives_seen++;
		end
		foreach (digs[i]) begin
			c.ascii_char = CHAR_ZERO + digs[i];
			c.last = (i == digs.size() - 1);
			c.char_count = c.last ? total[COUNT_W-1:0] : '0;
			expected_chars.push_back(c);
		end
		numbers_seen++;
		lengths_seen[total] = 1'b1;
	endfunction

	task check_char(text_item_t got);
		text_item_t want;
		if (expected_chars.size() == 0) begin
			report_mismatch($sformatf("char %h with nothing pending", got.ascii_char));
		end else begin
			want = expected_chars.pop_front();
			chars_checked++;
			if (got.ascii_char !== want.ascii_char)
				report_mismatch($sformatf("ascii_char %h, want %h",
					got.ascii_char, want.ascii_char));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %b, want %b on char %h",
					got.last, want.last, want.ascii_char));
			if (got.char_count !== want.char_count)
				report_mismatch($sformatf("char_count %0d, want %0d on char %h",
					got.char_count, want.char_count, want.ascii_char));
		end
	endtask
endclass

module tb_top;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 60;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 90;

	logic        clk;
	logic        arst_n;
	logic        num_valid;
	logic        num_ready;
	num_item_t   num;
	logic        text_valid;
	logic        text_ready;
	text_item_t  text;

	decimal_text_scoreboard sb;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	bit hold_start;
	int cycles;

	integer_to_decimal_ascii_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.num_valid  (num_valid),
		.num_ready  (num_ready),
		.num        (num),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text       (text)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_start) begin
			hold_left = HOLD_CYCLES;
			hold_start = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
		end
	end

	always @(negedge clk) begin
		text_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && text_valid && text_ready)
			sb.check_char(text);
	end

	// called at a falling edge, returns at the falling edge after accept
	task send_number(num_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			num_valid <= 1'b0;
			@(negedge clk);
		end
		num <= it;
		num_valid <= 1'b1;
		do @(posedge clk); while (!num_ready);
		sb.note_number(it);
		@(negedge clk);
	endtask

	task send_value(logic [31:0] v, logic s);
		num_item_t it;
		it.value = v;
		it.is_signed = s;
		send_number(it);
	endtask

	task wait_drained();
		num_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	function num_item_t random_number();
		num_item_t       it;
		longint unsigned p;
		longint unsigned mag;
		int              k;
		it.is_signed = 1'($urandom_range(1));
		case ($urandom_range(3))
			0: it.value = $urandom;
			1: begin
				k = $urandom_range(1, 10);
				p = 1;
				repeat (k) p = p * 10;
				mag = {$urandom} % p;
				it.value = mag[31:0];
				if (it.is_signed && $urandom_range(1))
					it.value = -it.value;
			end
			2: begin
				// next to a power of ten
				k = $urandom_range(0, 9);
				p = 1;
				repeat (k) p = p * 10;
				it.value = p[31:0] + $urandom_range(2) - 1;
				if (it.is_signed && $urandom_range(1))
					it.value = -it.value;
			end
			default: begin
				it.value = $urandom_range(20);
				if ($urandom_range(1))
					it.value = -it.value;
			end
		endcase
		return it;
	endfunction

	initial begin
		sb = new();
		cycles = 0;
		hold_left = 0;
		hold_start = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		num_valid = 1'b0;
		num = '0;
		text_ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed
		send_value(32'd0, 1'b0);
		send_value(32'd0, 1'b1);
		send_value(32'd1, 1'b1);
		send_value(32'd9, 1'b0);
		send_value(32'd10, 1'b0);
		send_value(32'd99, 1'b1);
		send_value(32'd100, 1'b0);
		send_value(32'd999999999, 1'b0);
		send_value(32'd1000000000, 1'b1);
		send_value(32'hFFFF_FFFF, 1'b0);
		send_value(32'hFFFF_FFFF, 1'b1);
		send_value(32'h8000_0000, 1'b1);
		send_value(32'h8000_0000, 1'b0);
		send_value(32'h7FFF_FFFF, 1'b1);
		send_value(32'h7FFF_FFFF, 1'b0);
		send_value(32'h8000_0001, 1'b1);
		send_value(-32'd10, 1'b1);
		send_value(-32'd9, 1'b1);
		send_value(32'hAAAA_AAAA, 1'b0);
		send_value(32'h5555_5555, 1'b1);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			repeat (PHASE_ITEMS) send_number(random_number());
			wait_drained();
		end

		// receiver holds off while numbers keep coming
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_start = 1'b1;
		repeat (8) send_number(random_number());
		wait_drained();

		repeat (TAIL_CYCLES) @(negedge clk);

		$display("tb_top: %0d numbers, %0d negative, %0d characters checked",
			sb.numbers_seen, sb.negatives_seen, sb.chars_checked);
		$display("tb_top: text lengths seen (bit n = n chars): %b", sb.lengths_seen);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d characters never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/i2da_pkg.sv
rtl/core/i2da_dabble.sv
rtl/core/i2da_emit.sv
rtl/core/integer_to_decimal_ascii_top.sv
tb/tb_top.sv
